>>> hdl/dfs_pkg.sv
`timescale 1ns / 1ps
package dfs_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_PUSH,
    ST_TOP,
    ST_EDGE,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

endpackage

>>> hdl/dfs_ram.sv
`timescale 1ns / 1ps
module dfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/dfs_topological_order.sv
`timescale 1ns / 1ps
// Topological sort of a task graph by depth-first walk, with cycle check.
// Configuration: APB-style port; register 0 (address 0) is vertex_count.
// Input: pulse start with in_opcode/in_from_task/in_to_task while busy is low.
//   Opcode edge appends one edge (busy stays low), so edge
//   beats can follow back to back; the link from the previous tail is
//   written in the background on the next cycle.
//   Opcode run walks the graph; busy rises on the next cycle and stays high
//   until the last result beat.
// Results: out_valid strobes one beat per cycle, out_task_number in
//   topological order with out_last_of_run on the final beat, or a single
//   beat with out_cycle_found set; no beat if vertex_count is 0. The receiver cannot stall.
// Run steps: a scan over the N vertices (vertex_count, clamped) for unvisited
//   start vertices, a push and a pop for every vertex reached, an edge read
//   for every edge walked, then a clear state, a read state and N result
//   beats on consecutive cycles. A cycle is reported in the cycle after the
//   back edge is seen.
// After reset and after every run the adjacency heads and marks read as
// cleared; the edge memories keep old contents but are never read stale.
module dfs_topological_order #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [6:0]  in_from_task,
  input  logic [6:0]  in_to_task,
  output logic        out_valid,
  output logic [6:0]  out_task_number,
  output logic        out_cycle_found,
  output logic        out_last_of_run
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = EW + 1;

  // Configuration register
  logic [6:0] vcount_r;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == dfs_pkg::REG_VERTEX_COUNT) ? {25'd0, vcount_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 7'd1;
    end else if (psel && penable && pwrite && paddr[2] == dfs_pkg::REG_VERTEX_COUNT) begin
      vcount_r <= pwdata[6:0];
    end
  end

  // Effective task count, clamped
  logic [VW:0] n_eff;
  assign n_eff = (vcount_r > 7'(MAX_VERTICES)) ? (VW+1)'(MAX_VERTICES)
                                               : (VW+1)'(vcount_r);

  // Flip-flop marks
  logic [MAX_VERTICES-1:0] head_vld_r, visited_r, onstk_r;
  logic [EW:0]   etotal_r;

  dfs_pkg::state_t state_r, state_nxt;

  // Walk registers
  logic [VW:0]   sp_r, sp_nxt, pos_r, pos_nxt, s_r, s_nxt, k_r, k_nxt;
  logic [VW-1:0] v_r, v_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic          cyc_r, cyc_nxt;

  // Pending link write to the previous tail of a list
  logic          lnk_pend_r;
  logic [EW-1:0] lnk_pend_e_r;

  // Edge load decode
  logic          ld;
  logic [VW-1:0] f0, t0;
  logic          edge_ok;
  assign ld      = start && !busy && in_opcode == dfs_pkg::OP_EDGE;
  assign edge_ok = in_from_task >= 7'd1 && in_from_task <= 7'(MAX_VERTICES) &&
                   in_to_task >= 7'd1 && in_to_task <= 7'(MAX_VERTICES) &&
                   etotal_r < (EW+1)'(MAX_EDGES);
  assign f0 = VW'(in_from_task - 7'd1);
  assign t0 = VW'(in_to_task - 7'd1);

  assign busy = state_r != dfs_pkg::ST_IDLE;

  // Edge memories
  logic          tgt_we, lnk_we;
  logic [EW-1:0] tgt_wa, lnk_wa, lnk_wd, e_ra;
  logic [VW-1:0] tgt_wd, tgt_rd;
  logic [EW-1:0] lnk_rd;

  dfs_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_tgt (
    .clk(clk), .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd), .raddr(e_ra), .rdata(tgt_rd));
  dfs_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_lnk (
    .clk(clk), .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd), .raddr(e_ra), .rdata(lnk_rd));

  // List head and tail memories, one entry per vertex
  logic          hd_we, tl_we;
  logic [VW-1:0] hd_ra, tl_ra;
  logic [EW-1:0] hd_rd, tl_rd;
  dfs_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head (
    .clk(clk), .we(hd_we), .waddr(f0), .wdata(etotal_r[EW-1:0]), .raddr(hd_ra),
    .rdata(hd_rd));
  dfs_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_tail (
    .clk(clk), .we(tl_we), .waddr(f0), .wdata(etotal_r[EW-1:0]), .raddr(tl_ra),
    .rdata(tl_rd));

  // Stack memory: vertex and cursor (cursor MSB marks none)
  logic          stk_we;
  logic [VW-1:0] stk_wa, stk_ra;
  logic [VW+CW-1:0] stk_wd, stk_rd;
  dfs_ram #(.WIDTH(VW+CW), .DEPTH(MAX_VERTICES)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));

  // Order buffer memory
  logic          ord_we;
  logic [VW-1:0] ord_wa, ord_wd, ord_ra, ord_rd;
  dfs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ord (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd));

  // Append edge: target now, tail now, head now for a list's first edge, old tail link next cycle
  assign tgt_we = ld && edge_ok;
  assign tgt_wa = etotal_r[EW-1:0];
  assign tgt_wd = t0;
  assign hd_we  = tgt_we && !head_vld_r[f0];
  assign tl_we  = tgt_we;
  assign lnk_we = lnk_pend_r;
  assign lnk_wa = tl_rd;
  assign lnk_wd = lnk_pend_e_r;

  // Look up the head of the vertex about to be pushed, the tail of the top (of the edge source while idle)
  assign hd_ra = v_nxt;
  assign tl_ra = busy ? v_r : f0;

  // Derived values in the walk
  logic [VW-1:0] svx, w;
  logic          c_none, last_e;
  assign svx    = s_r[VW-1:0];
  assign w      = tgt_rd;
  assign c_none = c_r[CW-1];
  assign last_e = c_r[EW-1:0] == tl_rd;

  always_comb begin
    state_nxt = state_r;
    sp_nxt = sp_r; pos_nxt = pos_r; s_nxt = s_r; k_nxt = k_r;
    v_nxt = v_r; c_nxt = c_r; cyc_nxt = cyc_r;
    e_ra = c_r[EW-1:0];
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = k_r[VW-1:0];
    out_valid = 1'b0; out_task_number = '0; out_cycle_found = 1'b0; out_last_of_run = 1'b0;
    case (state_r)
      dfs_pkg::ST_IDLE: begin
        if (start && in_opcode == dfs_pkg::OP_RUN) begin
          s_nxt = '0; pos_nxt = n_eff; cyc_nxt = 1'b0; sp_nxt = '0;
          state_nxt = dfs_pkg::ST_SCAN;
        end
      end
      // Find next unvisited start vertex
      dfs_pkg::ST_SCAN: begin
        if (s_r >= n_eff) begin
          state_nxt = dfs_pkg::ST_CLEAR;
        end else if (visited_r[svx]) begin
          s_nxt = s_r + 1'b1;
        end else begin
          v_nxt = svx;
          state_nxt = dfs_pkg::ST_PUSH;
        end
      end
      // Push v_r with its head cursor
      dfs_pkg::ST_PUSH: begin
        c_nxt = head_vld_r[v_r] ? {1'b0, hd_rd} : {1'b1, {EW{1'b0}}};
        stk_we = 1'b1; stk_wa = sp_r[VW-1:0]; stk_wd = {v_r, c_nxt};
        sp_nxt = sp_r + 1'b1;
        e_ra = c_nxt[EW-1:0];
        state_nxt = dfs_pkg::ST_TOP;
      end
      // Top frame in v_r/c_r; edge read issued for c_r
      dfs_pkg::ST_TOP: begin
        if (c_none) begin
          sp_nxt = sp_r - 1'b1;
          if (pos_r != '0) begin
            pos_nxt = pos_r - 1'b1;
            ord_we = 1'b1; ord_wa = pos_nxt[VW-1:0]; ord_wd = v_r;
          end
          if (sp_nxt == '0) begin
            s_nxt = s_r + 1'b1;
            state_nxt = dfs_pkg::ST_SCAN;
          end else begin
            stk_ra = VW'(sp_nxt - 1'b1);
            state_nxt = dfs_pkg::ST_EDGE;
            c_nxt = {1'b1, {EW{1'b1}}};
          end
        end else begin
          state_nxt = dfs_pkg::ST_EDGE;
        end
      end
      // Either reload a popped frame or consume an edge
      dfs_pkg::ST_EDGE: begin
        if (c_none) begin
          v_nxt = stk_rd[VW+CW-1:CW];
          c_nxt = stk_rd[CW-1:0];
          e_ra = c_nxt[EW-1:0];
          state_nxt = dfs_pkg::ST_TOP;
        end else begin
          c_nxt = last_e ? {1'b1, {EW{1'b0}}} : {1'b0, lnk_rd};
          stk_we = 1'b1; stk_wa = VW'(sp_r - 1'b1); stk_wd = {v_r, c_nxt};
          e_ra = c_nxt[EW-1:0];
          state_nxt = dfs_pkg::ST_TOP;
          if ({1'b0, w} < n_eff) begin
            if (!visited_r[w]) begin
              if (sp_r < (VW+1)'(MAX_VERTICES)) begin
                v_nxt = w;
                state_nxt = dfs_pkg::ST_PUSH;
              end
            end else if (onstk_r[w]) begin
              cyc_nxt = 1'b1;
              state_nxt = dfs_pkg::ST_CLEAR;
            end
          end
        end
      end
      // Clear marks and edge lists, then report
      dfs_pkg::ST_CLEAR: begin
        k_nxt = '0;
        if (cyc_r) begin
          out_valid = 1'b1; out_cycle_found = 1'b1; out_last_of_run = 1'b1;
          state_nxt = dfs_pkg::ST_IDLE;
        end else if (n_eff == '0) begin
          state_nxt = dfs_pkg::ST_IDLE;
        end else begin
          state_nxt = dfs_pkg::ST_EMIT_RD;
        end
      end
      dfs_pkg::ST_EMIT_RD: begin
        state_nxt = dfs_pkg::ST_EMIT;
      end
      dfs_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        out_task_number = 7'(ord_rd) + 7'd1;
        out_last_of_run = (k_r + 1'b1) == n_eff;
        k_nxt = k_r + 1'b1;
        ord_ra = k_nxt[VW-1:0];
        state_nxt = out_last_of_run ? dfs_pkg::ST_IDLE : dfs_pkg::ST_EMIT;
      end
      default: state_nxt = dfs_pkg::ST_IDLE;
    endcase
  end

  // Walk and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfs_pkg::ST_IDLE;
      head_vld_r <= '0; visited_r <= '0; onstk_r <= '0;
      etotal_r <= '0; cyc_r <= 1'b0; lnk_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cyc_r <= cyc_nxt;
      lnk_pend_r <= tgt_we && head_vld_r[f0];
      if (tgt_we) begin
        etotal_r <= etotal_r + 1'b1;
        head_vld_r[f0] <= 1'b1;
      end
      if (state_r == dfs_pkg::ST_PUSH) begin
        visited_r[v_r] <= 1'b1;
        onstk_r[v_r] <= 1'b1;
      end
      if (state_r == dfs_pkg::ST_TOP && c_none) onstk_r[v_r] <= 1'b0;
      if (state_r == dfs_pkg::ST_CLEAR) begin
        head_vld_r <= '0; visited_r <= '0; onstk_r <= '0; etotal_r <= '0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sp_r <= sp_nxt; pos_r <= pos_nxt; s_r <= s_nxt; k_r <= k_nxt;
    v_r <= v_nxt; c_r <= c_nxt;
    lnk_pend_e_r <= etotal_r[EW-1:0];
  end

endmodule

>>> dv/dfs_topological_order_tb.sv
`timescale 1ns / 1ps
module dfs_topological_order_tb;

  localparam int NV = 64;
  localparam int NE = 1024;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic        in_opcode = dfs_pkg::OP_EDGE;
  logic [6:0]  in_from_task = '0, in_to_task = '0;
  logic        out_valid;
  logic [6:0]  out_task_number;
  logic        out_cycle_found, out_last_of_run;

  typedef struct packed {
    logic [6:0] task_number;
    logic       cycle_found;
    logic       last_of_run;
  } order_beat_t;

  order_beat_t order_q[$];
  int          errors = 0;
  int          idle_cycles = 0;

  // predictor copy of the graph
  logic [6:0]  task_count;
  logic [5:0]  adj_to[NE];
  int          adj_next[NE];
  int          adj_head[NV];
  int          adj_tail[NV];
  int          edge_cnt;
  bit          seen[NV];
  bit          active[NV];

  dfs_topological_order uut (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .in_opcode(in_opcode),
    .in_from_task(in_from_task), .in_to_task(in_to_task),
    .out_valid(out_valid), .out_task_number(out_task_number),
    .out_cycle_found(out_cycle_found), .out_last_of_run(out_last_of_run)
  );

  always #4 clk = ~clk;

  function automatic void clear_graph();
    for (int i = 0; i < NV; i++) begin
      adj_head[i] = -1;
      seen[i] = 0;
      active[i] = 0;
    end
    edge_cnt = 0;
  endfunction

  // append one edge or walk the graph and queue the order
  function automatic void predict_order(logic op, logic [6:0] f, logic [6:0] t);
    int n, pos, sp, v, c, w;
    int stk_v[NV];
    int stk_c[NV];
    int ord[NV];
    bit cyc;
    order_beat_t b;
    if (op == dfs_pkg::OP_EDGE) begin
      if (f < 1 || f > NV || t < 1 || t > NV || edge_cnt >= NE) return;
      adj_to[edge_cnt] = 6'(t - 1);
      if (adj_head[f-1] < 0) adj_head[f-1] = edge_cnt;
      else adj_next[adj_tail[f-1]] = edge_cnt;
      adj_tail[f-1] = edge_cnt;
      edge_cnt++;
      return;
    end
    n = (task_count > NV) ? NV : task_count;
    pos = n;
    cyc = 0;
    for (int s = 0; s < n && !cyc; s++) begin
      if (seen[s]) continue;
      seen[s] = 1; active[s] = 1;
      stk_v[0] = s; stk_c[0] = adj_head[s]; sp = 1;
      while (sp > 0 && !cyc) begin
        v = stk_v[sp-1]; c = stk_c[sp-1];
        if (c < 0) begin
          sp--; active[v] = 0;
          if (pos > 0) begin pos--; ord[pos] = v; end
          continue;
        end
        w = adj_to[c];
        stk_c[sp-1] = (c == adj_tail[v]) ? -1 : adj_next[c];
        if (w >= n) continue;
        if (!seen[w]) begin
          if (sp < NV) begin
            seen[w] = 1; active[w] = 1;
            stk_v[sp] = w; stk_c[sp] = adj_head[w]; sp++;
          end
        end else if (active[w]) cyc = 1;
      end
    end
    clear_graph();
    if (cyc) begin
      b.task_number = '0; b.cycle_found = 1; b.last_of_run = 1;
      order_q.push_back(b);
      return;
    end
    for (int k = 0; k < n; k++) begin
      b.task_number = 7'(ord[k] + 1);
      b.cycle_found = 0;
      b.last_of_run = (k + 1 == n);
      order_q.push_back(b);
    end
  endfunction

  // pick a random gap, mostly short
  function automatic int gap_len();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    return g;
  endfunction

  // send one beat once busy is low; drop start only when a gap follows
  task automatic send_item(logic op, logic [6:0] f, logic [6:0] t);
    int g;
    start <= 1'b1; in_opcode <= op; in_from_task <= f; in_to_task <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_order(op, f, t);
    g = gap_len();
    if (g != 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (order_q.size() != 0 || busy) @(posedge clk);
    repeat (NV + 20) @(posedge clk);
  endtask

  task automatic write_task_count(logic [6:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * dfs_pkg::REG_VERTEX_COUNT); pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    task_count = val;
    @(posedge clk);
  endtask

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    order_beat_t exp_b;
    if (rst_n && out_valid) begin
      if (order_q.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual %0d/%0b/%0b", $time,
                 out_task_number, out_cycle_found, out_last_of_run);
        errors++;
      end else begin
        exp_b = order_q[0];
        order_q.delete(0);
        if (out_task_number !== exp_b.task_number)
          begin $display("%0t task_number: expected %0d, actual %0d", $time,
                   exp_b.task_number, out_task_number); errors++; end
        if (out_cycle_found !== exp_b.cycle_found)
          begin $display("%0t cycle_found: expected %0b, actual %0b", $time,
                   exp_b.cycle_found, out_cycle_found); errors++; end
        if (out_last_of_run !== exp_b.last_of_run)
          begin $display("%0t last_of_run: expected %0b, actual %0b", $time,
                   exp_b.last_of_run, out_last_of_run); errors++; end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (out_valid || (start && !busy) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_chain();
    write_task_count(7'd4);
    send_item(dfs_pkg::OP_EDGE, 7'd3, 7'd1);
    send_item(dfs_pkg::OP_EDGE, 7'd1, 7'd2);
    send_item(dfs_pkg::OP_EDGE, 7'd4, 7'd2);
    send_item(dfs_pkg::OP_EDGE, 7'd0, 7'd2);
    send_item(dfs_pkg::OP_EDGE, 7'd2, 7'd127);
    send_item(dfs_pkg::OP_EDGE, 7'd2, 7'd64);
    send_item(dfs_pkg::OP_RUN, 7'd127, 7'd127);
    wait_drain();
  endtask

  task automatic test_cycles();
    send_item(dfs_pkg::OP_EDGE, 7'd2, 7'd2);
    send_item(dfs_pkg::OP_RUN, 7'd0, 7'd0);
    send_item(dfs_pkg::OP_EDGE, 7'd1, 7'd3);
    send_item(dfs_pkg::OP_EDGE, 7'd3, 7'd4);
    send_item(dfs_pkg::OP_EDGE, 7'd4, 7'd1);
    send_item(dfs_pkg::OP_RUN, 7'd0, 7'd0);
    wait_drain();
  endtask

  task automatic test_extremes();
    write_task_count(7'd1);
    send_item(dfs_pkg::OP_EDGE, 7'd1, 7'd1);
    send_item(dfs_pkg::OP_RUN, 7'd0, 7'd0);
    wait_drain();
    write_task_count(7'd0);
    send_item(dfs_pkg::OP_EDGE, 7'd1, 7'd2);
    send_item(dfs_pkg::OP_RUN, 7'd0, 7'd0);
    wait_drain();
    write_task_count(7'd127);
    send_item(dfs_pkg::OP_EDGE, 7'd64, 7'd1);
    send_item(dfs_pkg::OP_EDGE, 7'd65, 7'd1);
    send_item(dfs_pkg::OP_RUN, 7'd0, 7'd0);
    wait_drain();
    write_task_count(7'd64);
    for (int i = 1; i < 64; i++) send_item(dfs_pkg::OP_EDGE, 7'(i), 7'(i + 1));
    send_item(dfs_pkg::OP_RUN, 7'd0, 7'd0);
    wait_drain();
  endtask

  task automatic test_random();
    int nv, ne, a, b;
    for (int r = 0; r < 12; r++) begin
      nv = (r % 5 == 4) ? $urandom_range(0, 127) : $urandom_range(2, 12);
      write_task_count(7'(nv));
      ne = $urandom_range(1, 14);
      for (int e = 0; e < ne; e++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(dfs_pkg::OP_EDGE, 7'($urandom), 7'($urandom));
        end else begin
          a = $urandom_range(1, (nv > 1 && nv < 65) ? nv : 16);
          b = $urandom_range(1, (nv > 1 && nv < 65) ? nv : 16);
          // mostly forward edges so many graphs stay acyclic
          if ($urandom_range(0, 3) != 0 && a > b) begin int tmp; tmp = a; a = b; b = tmp; end
          if (a == b && $urandom_range(0, 1)) b = a + 1;
          send_item(dfs_pkg::OP_EDGE, 7'(a), 7'(b));
        end
      end
      send_item(dfs_pkg::OP_RUN, 7'($urandom), 7'($urandom));
      wait_drain();
    end
  endtask

  initial begin
    clear_graph();
    task_count = 7'd1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (NV + 4) @(posedge clk);
    test_chain();
    test_cycles();
    test_extremes();
    test_random();
    if (errors == 0 && order_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> dfs_topological_order.f
hdl/dfs_pkg.sv
hdl/dfs_ram.sv
hdl/dfs_topological_order.sv
dv/dfs_topological_order_tb.sv
